/* rtl/wfp_pkg.sv */
// wfp_pkg: shared constants, codes, state type and unit request structs
// for the wall-following pid step core; depends on nothing
`timescale 1ns / 1ps
package wfp_pkg;

  localparam int DIST_BITS      = 13;
  localparam int SPEED_BITS     = 9;
  localparam int ERR_BITS       = DIST_BITS + 1;
  localparam int DIFF_BITS      = DIST_BITS + 2;
  localparam int INTEG_BITS     = 18;
  localparam int INTEGRAL_LIMIT = 100000;
  localparam int DZ_MM          = 10;
  localparam int GAIN_BITS      = 16;
  localparam int BASE_BITS      = 8;
  localparam int DT_BITS        = 16;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 16;

  // serial arithmetic widths
  localparam int ACC_W     = 58;
  localparam int MUL_Y_W   = 20;
  localparam int MUL_CNT_W = 5;
  localparam int DVD_W     = 56;
  localparam int DVS_W     = 34;
  localparam int DIV_CNT_W = 6;
  localparam int Q_W       = 26;
  localparam int SPD_W     = 28;
  localparam int FR_W      = 17;
  localparam int NUM_W     = 19;

  localparam logic [Q_W-1:0]     Q_CAP  = Q_W'(1) << (Q_W - 1);
  localparam logic [MUL_Y_W-1:0] K_MEGA = MUL_Y_W'(1000000);
  localparam logic [MUL_Y_W-1:0] K_KILO = MUL_Y_W'(1000);

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_P   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_I   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_D   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BASE     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX      = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRONT    = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FOLLOW   = 3'd7;

  // mode codes
  localparam logic [1:0] OP_CENTRE = 2'd0;
  localparam logic [1:0] OP_RIGHT  = 2'd1;
  localparam logic [1:0] OP_LEFT   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_INTEG,
    ST_DGAIN,
    ST_DSCALE,
    ST_PGAIN,
    ST_PSCALE,
    ST_IGAIN,
    ST_DT,
    ST_DIV,
    ST_SPLIT,
    ST_SCL_MUL,
    ST_SCL_DIV,
    ST_SCL_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                    load;
    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] x;
    logic [MUL_Y_W-1:0]      y;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic             load;
    logic [DVD_W-1:0] dvd;
    logic [DVS_W-1:0] dvs;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quo;
    logic           ovf;
    logic           rem_nz;
  } div_rsp_t;

endpackage

/* rtl/wfp_if.sv */
// wfp_if: valid/ready channel interfaces for tick items and result items
// depends on wfp_pkg for field widths
`timescale 1ns / 1ps
interface wfp_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     op;
  logic [wfp_pkg::DIST_BITS-1:0]  target_distance;
  logic [wfp_pkg::DIST_BITS-1:0]  left_dist;
  logic [wfp_pkg::DIST_BITS-1:0]  right_dist;
  logic [wfp_pkg::DIST_BITS-1:0]  center_dist;
  logic                           wall_left;
  logic                           wall_right;
  logic [wfp_pkg::DT_BITS-1:0]    elapsed_ms;

  modport source (output valid, op, target_distance, left_dist, right_dist, center_dist,
                  wall_left, wall_right, elapsed_ms, input ready);
  modport sink (input valid, op, target_distance, left_dist, right_dist, center_dist,
                wall_left, wall_right, elapsed_ms, output ready);
endinterface

interface wfp_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [wfp_pkg::SPEED_BITS-1:0] left_speed;
  logic signed [wfp_pkg::SPEED_BITS-1:0] right_speed;
  logic signed [wfp_pkg::ERR_BITS-1:0]   last_error;

  modport source (output valid, left_speed, right_speed, last_error, input ready);
  modport sink (input valid, left_speed, right_speed, last_error, output ready);
endinterface

/* rtl/wfp_mul_serial.sv */
// wfp_mul_serial: serial-parallel shift-add multiplier, one multiplier bit per cycle
// computes base + x * y; depends on wfp_pkg
`timescale 1ns / 1ps
module wfp_mul_serial (
  input  logic              clk,
  input  logic              rst,
  input  wfp_pkg::mul_req_t req,
  output wfp_pkg::mul_rsp_t rsp
);
  import wfp_pkg::*;

  localparam logic [MUL_CNT_W-1:0] LAST = MUL_CNT_W'(MUL_Y_W - 1);

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] xr;
  logic [MUL_Y_W-1:0]      yr;
  logic [MUL_CNT_W-1:0]    cnt;
  logic                    running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (req.load) begin
      acc     <= req.base;
      xr      <= req.x;
      yr      <= req.y;
      cnt     <= '0;
      running <= 1'b1;
    end else if (running) begin
      if (yr[0]) begin
        acc <= acc + xr;
      end
      xr  <= xr <<< 1;
      yr  <= yr >> 1;
      cnt <= cnt + MUL_CNT_W'(1);
      if (cnt == LAST) begin
        running <= 1'b0;
      end
    end
  end

  assign rsp.done = running && (cnt == LAST);
  assign rsp.prod = acc;

endmodule

/* rtl/wfp_div_serial.sv */
// wfp_div_serial: restoring divider, one quotient bit per cycle
// quotient overflow sets a sticky overflow flag; depends on wfp_pkg
`timescale 1ns / 1ps
module wfp_div_serial (
  input  logic              clk,
  input  logic              rst,
  input  wfp_pkg::div_req_t req,
  output wfp_pkg::div_rsp_t rsp
);
  import wfp_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(DVD_W - 1);

  logic [DVD_W-1:0]     dvd;
  logic [DVS_W-1:0]     dvs;
  logic [DVS_W-1:0]     rem;
  logic [Q_W-1:0]       quo;
  logic                 ovf;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 running;
  logic [DVS_W:0]       trial;
  logic [DVS_W:0]       diff;
  logic                 ge;

  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (req.load) begin
      dvd     <= req.dvd;
      dvs     <= req.dvs;
      rem     <= '0;
      quo     <= '0;
      ovf     <= 1'b0;
      cnt     <= '0;
      running <= 1'b1;
    end else if (running) begin
      rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd <= dvd << 1;
      quo <= {quo[Q_W-2:0], ge};
      ovf <= ovf | quo[Q_W-1];
      cnt <= cnt + DIV_CNT_W'(1);
      if (cnt == LAST) begin
        running <= 1'b0;
      end
    end
  end

  assign rsp.done   = running && (cnt == LAST);
  assign rsp.quo    = quo;
  assign rsp.ovf    = ovf;
  assign rsp.rem_nz = (rem != '0);

endmodule

/* rtl/wall_following_pid_step_core.sv */
// wall_following_pid_step_core: top level, sequencer and datapath of the pid step
// depends on wfp_pkg, wfp_if, wfp_mul_serial and wfp_div_serial
`timescale 1ns / 1ps
// One tick in, one result out. The block works on one tick at a time: the pid
// sum is built by a shift-add multiplier that takes one multiplier bit per cycle
// (seven products), then divided by 256000*dt in a restoring divider that yields
// one quotient bit per cycle. When the front wall is near, each wheel speed is
// scaled by one more product and divide. In centre mode with both walls missing,
// the tick skips the arithmetic and goes straight to the output state. The next
// tick is taken as soon as the result has moved into the output register, even
// if the sink has not yet taken that result. Configuration writes take effect at
// once and belong to idle periods.
module wall_following_pid_step_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wfp_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
  input  logic [wfp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  wfp_in_if.sink                              in_ch,
  wfp_out_if.source                           out_ch
);
  import wfp_pkg::*;

  localparam logic signed [ERR_BITS-1:0] DZ_POS  = ERR_BITS'(DZ_MM);
  localparam logic signed [ERR_BITS-1:0] DZ_NEG  = -DZ_POS;
  localparam logic signed [ACC_W-1:0]    LIM_POS = ACC_W'(INTEGRAL_LIMIT);
  localparam logic signed [ACC_W-1:0]    LIM_NEG = -LIM_POS;
  localparam logic [DIST_BITS-1:0]       FLOOR_MM = DIST_BITS'(50);

  // configuration registers
  logic [GAIN_BITS-1:0]         gain_p;
  logic [GAIN_BITS-1:0]         gain_i;
  logic [GAIN_BITS-1:0]         gain_d;
  logic [BASE_BITS-1:0]         cruise_speed;
  logic signed [SPEED_BITS-1:0] speed_floor;
  logic signed [SPEED_BITS-1:0] speed_ceil;
  logic [DIST_BITS-1:0]         front_threshold;
  logic [DIST_BITS-1:0]         follow_distance;

  // controller
  state_t state, state_next;
  logic   entry;
  logic   accept;

  // tick context
  logic signed [ERR_BITS-1:0]   raw;
  logic [DT_BITS-1:0]           dtv;
  logic                         p_raw;
  logic                         rwall;
  logic                         centre;
  logic                         scale_on;
  logic                         scale_zero;
  logic [FR_W-1:0]              fnum;
  logic [FR_W-1:0]              fden;

  // pid state and working registers
  logic signed [ERR_BITS-1:0]   prev;
  logic signed [INTEG_BITS-1:0] integ;
  logic signed [ERR_BITS-1:0]   e;
  logic signed [ERR_BITS-1:0]   p;
  logic signed [DIFF_BITS-1:0]  d;
  logic signed [ACC_W-1:0]      hold;
  logic                         neg_s;
  logic signed [SPD_W-1:0]      sl;
  logic signed [SPD_W-1:0]      sr;
  logic                         side;

  // output register
  logic                         out_valid;
  logic signed [SPEED_BITS-1:0] out_l;
  logic signed [SPEED_BITS-1:0] out_r;
  logic signed [ERR_BITS-1:0]   out_e;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;

  // decode of an incoming tick
  logic [DT_BITS-1:0]         dt_in;
  logic signed [ERR_BITS-1:0] raw_in;
  logic [DT_BITS-1:0]         dt_sel;
  logic                       p_raw_in;
  logic                       rwall_in;
  logic                       centre_in;
  logic                       both_miss;
  logic                       clear_integ;
  logic [FR_W-1:0]            t_off;
  logic signed [NUM_W-1:0]    num_s;
  logic                       low_thr;

  // datapath helpers
  logic                       dz;
  logic signed [ERR_BITS-1:0] e_dz;
  logic signed [ACC_W-1:0]    prod_abs;
  logic [22:0]                dt125;
  logic [DVS_W-1:0]           pid_den;
  logic [SPD_W-1:0]           qv;
  logic signed [SPD_W-1:0]    qs;
  logic signed [SPD_W-1:0]    bse;
  logic signed [SPD_W-1:0]    plus_v;
  logic signed [SPD_W-1:0]    minus_v;
  logic signed [SPD_W-1:0]    lo_v;
  logic signed [SPD_W-1:0]    hi_v;
  logic signed [SPD_W-1:0]    s_cur;
  logic signed [SPD_W-1:0]    s_mag;
  logic                       skip;
  logic signed [SPD_W-1:0]    fin_v;
  logic signed [SPD_W-1:0]    fin_st;
  logic                       out_load;

  function automatic logic signed [SPD_W-1:0] clamp_spd(
    input logic signed [SPD_W-1:0]      x,
    input logic signed [SPEED_BITS-1:0] lo,
    input logic signed [SPEED_BITS-1:0] hi
  );
    logic signed [SPD_W-1:0] lo_w;
    logic signed [SPD_W-1:0] hi_w;
    lo_w = SPD_W'(lo);
    hi_w = SPD_W'(hi);
    if (x < lo_w) begin
      return lo_w;
    end else if (x > hi_w) begin
      return hi_w;
    end
    return x;
  endfunction

  wfp_mul_serial u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));
  wfp_div_serial u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && (state == ST_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p          <= GAIN_BITS'(256);
      gain_i          <= '0;
      gain_d          <= '0;
      cruise_speed    <= BASE_BITS'(150);
      speed_floor     <= '0;
      speed_ceil      <= SPEED_BITS'(255);
      front_threshold <= DIST_BITS'(150);
      follow_distance <= DIST_BITS'(55);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_GAIN_P: gain_p          <= cfg_data[GAIN_BITS-1:0];
        CFG_GAIN_I: gain_i          <= cfg_data[GAIN_BITS-1:0];
        CFG_GAIN_D: gain_d          <= cfg_data[GAIN_BITS-1:0];
        CFG_BASE:   cruise_speed    <= cfg_data[BASE_BITS-1:0];
        CFG_MIN:    speed_floor     <= cfg_data[SPEED_BITS-1:0];
        CFG_MAX:    speed_ceil      <= cfg_data[SPEED_BITS-1:0];
        CFG_FRONT:  front_threshold <= cfg_data[DIST_BITS-1:0];
        CFG_FOLLOW: follow_distance <= cfg_data[DIST_BITS-1:0];
        default:    ;
      endcase
    end
  end

  // tick decode: pick the error source, time step and wheel orientation
  always_comb begin
    dt_in       = (in_ch.elapsed_ms == '0) ? DT_BITS'(1) : in_ch.elapsed_ms;
    both_miss   = 1'b0;
    clear_integ = 1'b0;
    p_raw_in    = 1'b0;
    centre_in   = 1'b0;
    rwall_in    = 1'b0;
    dt_sel      = dt_in;
    raw_in      = '0;
    priority if (in_ch.op == OP_RIGHT) begin
      raw_in   = $signed({1'b0, in_ch.right_dist}) - $signed({1'b0, in_ch.target_distance});
      rwall_in = 1'b1;
    end else if (in_ch.op == OP_LEFT) begin
      raw_in = $signed({1'b0, in_ch.left_dist}) - $signed({1'b0, in_ch.target_distance});
    end else if (!in_ch.wall_left && !in_ch.wall_right) begin
      both_miss   = 1'b1;
      clear_integ = 1'b1;
    end else if (!in_ch.wall_right) begin
      // opening on the right: hold the left wall at the follow distance
      raw_in      = $signed({1'b0, in_ch.left_dist}) - $signed({1'b0, follow_distance});
      dt_sel      = DT_BITS'(1);
      clear_integ = 1'b1;
    end else if (!in_ch.wall_left) begin
      raw_in      = $signed({1'b0, in_ch.right_dist}) - $signed({1'b0, follow_distance});
      dt_sel      = DT_BITS'(1);
      rwall_in    = 1'b1;
      clear_integ = 1'b1;
    end else begin
      raw_in    = $signed({1'b0, in_ch.left_dist}) - $signed({1'b0, in_ch.right_dist});
      p_raw_in  = 1'b1;
      centre_in = 1'b1;
    end
  end

  // front slow-down factor num/den
  always_comb begin
    low_thr = (front_threshold <= FLOOR_MM);
    t_off   = FR_W'(front_threshold) - FR_W'(FLOOR_MM);
    num_s   = $signed(NUM_W'(front_threshold) + (NUM_W'(front_threshold) << 1))
            + $signed(NUM_W'(in_ch.center_dist) + (NUM_W'(in_ch.center_dist) << 2))
            - NUM_W'(400);
  end

  // pid and division helpers
  always_comb begin
    dz       = (raw > DZ_NEG) && (raw < DZ_POS);
    e_dz     = dz ? '0 : raw;
    prod_abs = mrsp.prod[ACC_W-1] ? -mrsp.prod : mrsp.prod;
    dt125    = (23'(dtv) << 7) - (23'(dtv) << 2) + 23'(dtv);
    pid_den  = {dt125, 11'b0};
    qv       = drsp.ovf ? SPD_W'(Q_CAP) : SPD_W'(drsp.quo);
    qs       = $signed(qv);
    bse      = $signed(SPD_W'(cruise_speed));
    plus_v   = bse + qs;
    // truncation toward zero of base minus a positive fraction
    minus_v  = bse - qs - SPD_W'(drsp.rem_nz && (bse > qs));
    lo_v     = neg_s ? plus_v : minus_v;
    hi_v     = neg_s ? minus_v : plus_v;
    s_cur    = side ? sr : sl;
    s_mag    = s_cur[SPD_W-1] ? -s_cur : s_cur;
    skip     = !scale_on || scale_zero;
    if (skip) begin
      fin_v = scale_on ? '0 : s_cur;
    end else begin
      fin_v = s_cur[SPD_W-1] ? -qs : qs;
    end
    // follow modes scale first and clamp after; centre clamped before scaling
    fin_st   = centre ? fin_v : clamp_spd(fin_v, speed_floor, speed_ceil);
    out_load = (state == ST_OUT) && (!out_valid || out_ch.ready);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (accept) state_next = both_miss ? ST_OUT : ST_EVAL;
      ST_EVAL:    state_next = ST_INTEG;
      ST_INTEG:   if (mrsp.done) state_next = ST_DGAIN;
      ST_DGAIN:   if (mrsp.done) state_next = ST_DSCALE;
      ST_DSCALE:  if (mrsp.done) state_next = ST_PGAIN;
      ST_PGAIN:   if (mrsp.done) state_next = ST_PSCALE;
      ST_PSCALE:  if (mrsp.done) state_next = ST_IGAIN;
      ST_IGAIN:   if (mrsp.done) state_next = ST_DT;
      ST_DT:      if (mrsp.done) state_next = ST_DIV;
      ST_DIV:     if (drsp.done) state_next = ST_SPLIT;
      ST_SPLIT:   state_next = ST_SCL_MUL;
      ST_SCL_MUL: begin
        if (skip) state_next = ST_SCL_FIN;
        else if (mrsp.done) state_next = ST_SCL_DIV;
      end
      ST_SCL_DIV: if (drsp.done) state_next = ST_SCL_FIN;
      ST_SCL_FIN: state_next = side ? ST_OUT : ST_SCL_MUL;
      ST_OUT:     if (out_load) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      entry <= 1'b0;
    end else begin
      state <= state_next;
      entry <= (state_next != state);
    end
  end

  // multiplier operand select, loaded on the first cycle of each product state
  always_comb begin
    mreq.load = 1'b0;
    mreq.base = '0;
    mreq.x    = '0;
    mreq.y    = '0;
    unique case (state)
      ST_INTEG: begin
        mreq.load = entry;
        mreq.base = ACC_W'(integ);
        mreq.x    = ACC_W'(e);
        mreq.y    = MUL_Y_W'(dtv);
      end
      ST_DGAIN: begin
        mreq.load = entry;
        mreq.x    = ACC_W'(d);
        mreq.y    = MUL_Y_W'(gain_d);
      end
      ST_DSCALE: begin
        mreq.load = entry;
        mreq.x    = mrsp.prod;
        mreq.y    = K_MEGA;
      end
      ST_PGAIN: begin
        mreq.load = entry;
        mreq.x    = ACC_W'(p);
        mreq.y    = MUL_Y_W'(gain_p);
      end
      ST_PSCALE: begin
        mreq.load = entry;
        mreq.x    = mrsp.prod;
        mreq.y    = K_KILO;
      end
      ST_IGAIN: begin
        mreq.load = entry;
        mreq.base = mrsp.prod;
        mreq.x    = ACC_W'(integ);
        mreq.y    = MUL_Y_W'(gain_i);
      end
      ST_DT: begin
        mreq.load = entry;
        mreq.base = hold;
        mreq.x    = mrsp.prod;
        mreq.y    = MUL_Y_W'(dtv);
      end
      ST_SCL_MUL: begin
        mreq.load = entry && !skip;
        mreq.x    = ACC_W'(s_mag);
        mreq.y    = MUL_Y_W'(fnum);
      end
      default: ;
    endcase
  end

  // divider operand select
  always_comb begin
    dreq.load = 1'b0;
    dreq.dvd  = '0;
    dreq.dvs  = '0;
    unique case (state)
      ST_DIV: begin
        dreq.load = entry;
        dreq.dvd  = prod_abs[DVD_W-1:0];
        dreq.dvs  = pid_den;
      end
      ST_SCL_DIV: begin
        dreq.load = entry;
        dreq.dvd  = mrsp.prod[DVD_W-1:0];
        dreq.dvs  = DVS_W'(fden);
      end
      default: ;
    endcase
  end

  // pid state: previous error and integral
  always_ff @(posedge clk) begin
    if (rst) begin
      prev  <= '0;
      integ <= '0;
    end else begin
      if (accept && clear_integ) begin
        integ <= '0;
      end
      if (state == ST_EVAL) begin
        prev <= e_dz;
        if (dz) begin
          integ <= '0;
        end
      end
      // integral update lands on the first cycle after its product
      if (state == ST_DGAIN && entry) begin
        if (mrsp.prod > LIM_POS) begin
          integ <= INTEG_BITS'(LIM_POS);
        end else if (mrsp.prod < LIM_NEG) begin
          integ <= INTEG_BITS'(LIM_NEG);
        end else begin
          integ <= INTEG_BITS'(mrsp.prod);
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      raw        <= raw_in;
      dtv        <= dt_sel;
      p_raw      <= p_raw_in;
      rwall      <= rwall_in;
      centre     <= centre_in;
      scale_on   <= (in_ch.center_dist < front_threshold);
      scale_zero <= low_thr ? 1'b0 : (num_s <= $signed(NUM_W'(0)));
      fnum       <= low_thr ? FR_W'(3) : num_s[FR_W-1:0];
      fden       <= low_thr ? FR_W'(10) : ((t_off << 3) + (t_off << 1));
      sl         <= bse;
      sr         <= bse;
    end
    if (state == ST_EVAL) begin
      e <= e_dz;
      p <= p_raw ? raw : e_dz;
      d <= DIFF_BITS'(e_dz) - DIFF_BITS'(prev);
    end
    if (state == ST_PGAIN && entry) begin
      hold <= mrsp.prod;
    end
    if (state == ST_DIV && entry) begin
      neg_s <= mrsp.prod[ACC_W-1];
    end
    if (state == ST_SPLIT) begin
      side <= 1'b0;
      if (centre) begin
        sl <= clamp_spd(lo_v, speed_floor, speed_ceil);
        sr <= clamp_spd(hi_v, speed_floor, speed_ceil);
      end else if (rwall) begin
        sl <= hi_v;
        sr <= lo_v;
      end else begin
        sl <= lo_v;
        sr <= hi_v;
      end
    end
    if (state == ST_SCL_FIN) begin
      side <= 1'b1;
      if (side) begin
        sr <= fin_st;
      end else begin
        sl <= fin_st;
      end
    end
  end

  // output register: a waiting result does not hold off the next tick
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_l <= sl[SPEED_BITS-1:0];
      out_r <= sr[SPEED_BITS-1:0];
      out_e <= prev;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.left_speed  = out_l;
  assign out_ch.right_speed = out_r;
  assign out_ch.last_error  = out_e;

endmodule
